// ===== rtl/core/uwg_pkg.sv =====
// Shared types and constants for the 1-D unfold window gather block.
// Holds the request and response beat layouts, register codes and FSM states.
// No dependencies.
package uwg_pkg;

   // Fixed field widths of the request and response beats.
   localparam int FRAME_W = 7;
   localparam int CHAN_W  = 5;
   localparam int DATA_W  = 32;
   localparam int COL_W   = 9;

   // Stride is clamped to 1..STRIDE_MAX independent of any module parameter.
   localparam int STRIDE_MAX = 16;
   localparam int ST_W       = 5;

   // Product of an output frame and the stride.
   localparam int JST_W = FRAME_W + ST_W;

   // Register file layout.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [4:0] KERNEL_SIZE_RESET   = 5'd3;
   localparam logic [4:0] STRIDE_RESET        = 5'd1;
   localparam logic [5:0] NUM_CHANNELS_RESET  = 6'd32;
   localparam logic [7:0] NUM_IN_FRAMES_RESET = 8'd128;

   // Operation codes of a request beat.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef enum logic [1:0] {
      REG_KERNEL_SIZE,
      REG_STRIDE,
      REG_NUM_CHANNELS,
      REG_NUM_IN_FRAMES
   } csr_index_type;

   typedef struct packed {
      logic [4:0] kernel_size;
      logic [4:0] stride;
      logic [5:0] num_channels;
      logic [7:0] num_in_frames;
   } cfg_regs_type;

   typedef struct packed {
      logic               op;
      logic [FRAME_W-1:0] in_frame;
      logic [CHAN_W-1:0]  in_channel;
      logic [DATA_W-1:0]  in_word;
      logic [FRAME_W-1:0] out_frame;
      logic [COL_W-1:0]   out_col;
   } req_item_type;

   typedef struct packed {
      logic [DATA_W-1:0] out_word;
      logic              padded;
      logic              index_error;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_LOCATE,
      ST_FETCH,
      ST_REPLY
   } gather_state_type;

endpackage

// ===== rtl/core/uwg_csr.sv =====
// Configuration register file with an APB-style access port.
// Depends on uwg_pkg for the register layout and reset values.
module uwg_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [uwg_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [uwg_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [uwg_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready,
   output uwg_pkg::cfg_regs_type             cfg_regs
);
   import uwg_pkg::*;

   cfg_regs_type  cfg_ff;
   cfg_regs_type  cfg_in;
   csr_index_type index;
   logic          wr_beat;

   assign index   = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_beat = psel & penable & pwrite;
   assign pready  = 1'b1;

   // Register update on the access phase of a write beat.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_beat) begin
         unique case (index)
            REG_KERNEL_SIZE:   cfg_in.kernel_size   = pwdata[4:0];
            REG_STRIDE:        cfg_in.stride        = pwdata[4:0];
            REG_NUM_CHANNELS:  cfg_in.num_channels  = pwdata[5:0];
            REG_NUM_IN_FRAMES: cfg_in.num_in_frames = pwdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kernel_size   <= KERNEL_SIZE_RESET;
         cfg_ff.stride        <= STRIDE_RESET;
         cfg_ff.num_channels  <= NUM_CHANNELS_RESET;
         cfg_ff.num_in_frames <= NUM_IN_FRAMES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read data mux.
   always_comb begin
      unique case (index)
         REG_KERNEL_SIZE:   prdata = CSR_DATA_W'(cfg_ff.kernel_size);
         REG_STRIDE:        prdata = CSR_DATA_W'(cfg_ff.stride);
         REG_NUM_CHANNELS:  prdata = CSR_DATA_W'(cfg_ff.num_channels);
         REG_NUM_IN_FRAMES: prdata = CSR_DATA_W'(cfg_ff.num_in_frames);
         default:           prdata = '0;
      endcase
   end

   assign cfg_regs = cfg_ff;

endmodule

// ===== rtl/core/uwg_divider.sv =====
// Restoring divider that splits an output column into channel and tap.
// One quotient bit per cycle. Depends on uwg_pkg for the column width.
module uwg_divider #(
   parameter int DIVISOR_W = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [uwg_pkg::COL_W-1:0]   dividend,
   input  logic [DIVISOR_W-1:0]        divisor,
   output logic                        done,
   output logic [uwg_pkg::COL_W-1:0]   quotient,
   output logic [DIVISOR_W-1:0]        remainder
);
   import uwg_pkg::*;

   localparam int CNT_W = $clog2(COL_W);

   logic [COL_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 running_ff, running_in;
   logic                 done_ff, done_in;
   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;
   logic                 fits;

   // One shift-and-subtract step.
   always_comb begin
      trial = {rem_ff, quo_ff[COL_W-1]};
      fits  = trial >= {1'b0, divisor};
      diff  = trial - {1'b0, divisor};
   end

   always_comb begin
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      count_in   = count_ff;
      running_in = running_ff;
      done_in    = 1'b0;
      if (start) begin
         quo_in     = dividend;
         rem_in     = '0;
         count_in   = '0;
         running_in = 1'b1;
      end else if (running_ff) begin
         quo_in   = {quo_ff[COL_W-2:0], fits};
         rem_in   = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         count_in = count_ff + CNT_W'(1);
         if (count_ff == CNT_W'(COL_W - 1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         count_ff   <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/core/uwg_store.sv =====
// Sample store: one write port and one read port with registered read data.
// Entries are undefined until written. Depends on nothing.
module uwg_store #(
   parameter int ADDR_W = 12,
   parameter int WORD_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WORD_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [WORD_W-1:0] store_mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   // Synchronous write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/unfold_1d_window_gather.sv =====
// 1-D unfold (im2col) gather over a frames-by-channels sample store.
// Instantiates uwg_csr, uwg_divider and uwg_store; depends on uwg_pkg.
//
// Usage: a request beat is taken on a rising edge with start high and busy
// low. A write beat stores in_word at (in_frame, in_channel); a read beat
// returns the word of output frame out_frame, column out_col of the unfolded
// matrix, zero with padded set for taps outside the sequence, or zero with
// index_error set for indices beyond the configured sizes. Every request
// gives one response beat, shown for a single cycle with rsp_strobe high;
// the receiver cannot hold it off.
// Timing: a write or an index error answers in the cycle after the request and
// busy stays low, so one such request fits in every cycle. A read runs the
// column through a one-bit-per-cycle divider, whose done register hands the
// result over; ST_LOCATE then finds the source frame, and for a gathered word
// ST_FETCH reads the store and ST_REPLY replies; a padded read answers from
// ST_LOCATE. Busy drops in the cycle that the response beat of a read is
// shown, and the next request is taken once busy drops. The serial divider
// takes most of a read's time. Reset returns the registers to their defaults
// and the control to idle; the store contents are undefined until written.
// The configuration port must be written by the user only while no request
// is in flight; the block does not enforce this.
module unfold_1d_window_gather #(
   parameter int MAX_FRAMES   = 128,
   parameter int MAX_CHANNELS = 32,
   parameter int WORD_BITS    = 32,
   parameter int MAX_KERNEL   = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel.
   input  logic                             start,
   output logic                             busy,
   input  uwg_pkg::req_item_type            req_item,
   // Response channel.
   output logic                             rsp_strobe,
   output uwg_pkg::rsp_item_type            rsp_item,
   // Configuration port.
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [uwg_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [uwg_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [uwg_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import uwg_pkg::*;

   localparam int KS_W   = $clog2(MAX_KERNEL + 1);
   localparam int NC_W   = $clog2(MAX_CHANNELS + 1);
   localparam int NF_W   = $clog2(MAX_FRAMES + 1);
   localparam int FR_W   = $clog2(MAX_FRAMES);
   localparam int ADDR_W = $clog2(MAX_FRAMES * MAX_CHANNELS);
   localparam int JL_W   = FRAME_W + 1 + ST_W;
   localparam int CL_W   = NC_W + KS_W;
   localparam int POS_W  = JST_W + 1;

   cfg_regs_type     cfg_regs;
   gather_state_type state_ff, state_in;
   rsp_item_type     rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [JST_W-1:0] jst_ff, jst_in;
   logic [FR_W-1:0]  src_ff, src_in;

   logic [KS_W-1:0]   ks;
   logic [ST_W-1:0]   st;
   logic [NC_W-1:0]   nc;
   logic [NF_W-1:0]   nf;
   logic [JL_W-1:0]   frame_lim;
   logic [CL_W-1:0]   col_lim;
   logic [JST_W-1:0]  jst_w;
   logic              index_err;
   logic              is_read;
   logic              wr_in_range;
   logic [POS_W-1:0]  pos;
   logic [KS_W-1:0]   half;
   logic              pad;

   logic              div_start;
   logic              div_done;
   logic [COL_W-1:0]  div_quo;
   logic [KS_W-1:0]   div_rem;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [WORD_BITS-1:0] rd_data;

   uwg_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .cfg_regs (cfg_regs)
   );

   uwg_divider #(
      .DIVISOR_W (KS_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_item.out_col),
      .divisor   (ks),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   uwg_store #(
      .ADDR_W (ADDR_W),
      .WORD_W (WORD_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_item.in_word[WORD_BITS-1:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Registers saturated into their legal ranges; zero acts as one.
   always_comb begin
      if (cfg_regs.kernel_size == '0) begin
         ks = KS_W'(1);
      end else if (32'(cfg_regs.kernel_size) > MAX_KERNEL) begin
         ks = KS_W'(MAX_KERNEL);
      end else begin
         ks = KS_W'(cfg_regs.kernel_size);
      end

      if (cfg_regs.stride == '0) begin
         st = ST_W'(1);
      end else if (32'(cfg_regs.stride) > STRIDE_MAX) begin
         st = ST_W'(STRIDE_MAX);
      end else begin
         st = cfg_regs.stride;
      end

      if (cfg_regs.num_channels == '0) begin
         nc = NC_W'(1);
      end else if (32'(cfg_regs.num_channels) > MAX_CHANNELS) begin
         nc = NC_W'(MAX_CHANNELS);
      end else begin
         nc = NC_W'(cfg_regs.num_channels);
      end

      if (cfg_regs.num_in_frames == '0) begin
         nf = NF_W'(1);
      end else if (32'(cfg_regs.num_in_frames) > MAX_FRAMES) begin
         nf = NF_W'(MAX_FRAMES);
      end else begin
         nf = NF_W'(cfg_regs.num_in_frames);
      end
   end

   // Request checks. The frame bound j < nf/stride is tested as (j+1)*stride <= nf.
   always_comb begin
      frame_lim   = (JL_W'(req_item.out_frame) + JL_W'(1)) * JL_W'(st);
      col_lim     = CL_W'(nc) * CL_W'(ks);
      index_err   = (32'(frame_lim) > 32'(nf)) || (32'(req_item.out_col) >= 32'(col_lim));
      jst_w       = JST_W'(req_item.out_frame) * JST_W'(st);
      is_read     = req_item.op == OP_READ;
      wr_in_range = (32'(req_item.in_frame) < MAX_FRAMES)
                    && (32'(req_item.in_channel) < MAX_CHANNELS);
      wr_addr     = ADDR_W'(32'(req_item.in_frame) * MAX_CHANNELS
                            + 32'(req_item.in_channel));
   end

   // Source frame from the tap; padded when it leaves the sequence.
   always_comb begin
      pos    = POS_W'(jst_ff) + POS_W'(div_rem);
      half   = ks >> 1;
      pad    = (32'(pos) < 32'(half)) || ((32'(pos) - 32'(half)) >= 32'(nf));
      rd_addr = ADDR_W'(32'(src_ff) * MAX_CHANNELS + 32'(div_quo));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && is_read && !index_err) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_LOCATE;
            end
         end
         ST_LOCATE: begin
            state_in = pad ? ST_IDLE : ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State outputs: store access, divider start and the response beat.
   always_comb begin
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      div_start    = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      jst_in       = jst_ff;
      src_in       = src_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (!is_read) begin
                  wr_en        = wr_in_range;
                  rsp_valid_in = 1'b1;
               end else if (index_err) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.index_error = 1'b1;
               end else begin
                  div_start = 1'b1;
                  jst_in    = jst_w;
               end
            end
         end
         ST_DIVIDE: begin
            jst_in = jst_ff;
         end
         ST_LOCATE: begin
            src_in = FR_W'(pos - POS_W'(half));
            if (pad) begin
               rsp_valid_in  = 1'b1;
               rsp_in.padded = 1'b1;
            end
         end
         ST_FETCH: begin
            rd_en = 1'b1;
         end
         ST_REPLY: begin
            rsp_valid_in    = 1'b1;
            rsp_in.out_word = DATA_W'(rd_data);
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      jst_ff <= jst_in;
      src_ff <= src_in;
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the 1-D unfold window gather block.
// Drives request beats and register writes, and predicts every response beat.
// Depends on uwg_pkg and the unfold_1d_window_gather RTL.
module tb_top;
   import uwg_pkg::*;

   localparam int STORE_CH    = 32;
   localparam int STORE_DEPTH = 128 * STORE_CH;
   localparam int NO_FETCH    = -1;
   localparam int LATENCY     = 16;

   // Mirror of the sample store and registers; holds the response beats still owed.
   class gather_scoreboard;
      rsp_item_type      rsp_due[$];
      logic [DATA_W-1:0] sample_mem [STORE_DEPTH];
      bit                filled [STORE_DEPTH];
      logic [4:0]        kernel_size   = KERNEL_SIZE_RESET;
      logic [4:0]        stride        = STRIDE_RESET;
      logic [5:0]        num_channels  = NUM_CHANNELS_RESET;
      logic [7:0]        num_in_frames = NUM_IN_FRAMES_RESET;
      int                fail_count    = 0;

      function void set_reg(csr_index_type idx, logic [31:0] value);
         case (idx)
            REG_KERNEL_SIZE:   kernel_size   = value[4:0];
            REG_STRIDE:        stride        = value[4:0];
            REG_NUM_CHANNELS:  num_channels  = value[5:0];
            REG_NUM_IN_FRAMES: num_in_frames = value[7:0];
            default: ;
         endcase
      endfunction

      function int sat(int v, int lo, int hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      // Registers as the block uses them, saturated into their legal ranges.
      function void eff_sizes(output int ks, output int st, output int nc, output int nf);
         ks = sat(int'(kernel_size), 1, 16);
         st = sat(int'(stride), 1, STRIDE_MAX);
         nc = sat(int'(num_channels), 1, 32);
         nf = sat(int'(num_in_frames), 1, 128);
      endfunction

      // Output frames and columns that a read may name without an index error.
      function void out_limits(output int frames, output int cols);
         int ks, st, nc, nf;
         eff_sizes(ks, st, nc, nf);
         frames = nf / st;
         cols   = nc * ks;
      endfunction

      // Store address a read beat gathers from, or NO_FETCH on padding or an index error.
      function int fetch_addr(req_item_type r, output bit pad, output bit err);
         int ks, st, nc, nf, frames, cols, tap, half, pos;
         eff_sizes(ks, st, nc, nf);
         out_limits(frames, cols);
         pad = 1'b0;
         err = 1'b0;
         if (int'(r.out_frame) >= frames || int'(r.out_col) >= cols) begin
            err = 1'b1;
            return NO_FETCH;
         end
         tap  = int'(r.out_col) % ks;
         half = ks / 2;
         pos  = int'(r.out_frame) * st + tap;
         if (pos < half || pos - half >= nf) begin
            pad = 1'b1;
            return NO_FETCH;
         end
         return (pos - half) * STORE_CH + int'(r.out_col) / ks;
      endfunction

      // Apply an accepted request beat and queue the response it owes.
      function void record_request(req_item_type r);
         rsp_item_type beat;
         int addr;
         bit pad, err;
         beat = '0;
         if (r.op == OP_WRITE) begin
            addr = int'(r.in_frame) * STORE_CH + int'(r.in_channel);
            sample_mem[addr] = r.in_word;
            filled[addr] = 1'b1;
         end else begin
            addr = fetch_addr(r, pad, err);
            beat.padded      = pad;
            beat.index_error = err;
            if (addr != NO_FETCH) beat.out_word = sample_mem[addr];
         end
         rsp_due.push_back(beat);
      endfunction

      // Compare a response beat with the oldest one owed.
      function void check_response(rsp_item_type got);
         rsp_item_type want;
         if (rsp_due.size() == 0) begin
            $error("response beat with none owed: out_word %h", got.out_word);
            fail_count++;
            return;
         end
         want = rsp_due.pop_front();
         if (got.out_word !== want.out_word) begin
            $error("out_word: expected %h, actual %h", want.out_word, got.out_word);
            fail_count++;
         end
         if (got.padded !== want.padded) begin
            $error("padded: expected %b, actual %b", want.padded, got.padded);
            fail_count++;
         end
         if (got.index_error !== want.index_error) begin
            $error("index_error: expected %b, actual %b", want.index_error, got.index_error);
            fail_count++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_item_type          req_item;
   logic                  rsp_strobe;
   rsp_item_type          rsp_item;
   logic                  psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   gather_scoreboard gather_sb = new();
   int beat_count = 0;

   unfold_1d_window_gather u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Every strobed response beat is checked at the edge that ends it.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) gather_sb.check_response(rsp_item);
   end

   function automatic req_item_type random_fields();
      req_item_type r;
      r.op         = 1'($urandom);
      r.in_frame   = FRAME_W'($urandom);
      r.in_channel = CHAN_W'($urandom);
      r.in_word    = $urandom;
      r.out_frame  = FRAME_W'($urandom);
      r.out_col    = COL_W'($urandom);
      return r;
   endfunction

   // Present one request beat and hold it until the block takes it.
   task automatic send_beat(req_item_type r);
      bit quiet;
      quiet = (beat_count >= 300 && beat_count < 500);
      if (!quiet) begin
         while ($urandom_range(0, 99) < 17) begin
            @(negedge clock);
            start    = 1'b0;
            req_item = random_fields();
         end
      end
      @(negedge clock);
      start    = 1'b1;
      req_item = r;
      @(posedge clock);
      while (busy) @(posedge clock);
      gather_sb.record_request(r);
      beat_count++;
   endtask

   // A read of a never-written entry is first preceded by a write to it.
   task automatic send_read(req_item_type r);
      req_item_type fill;
      int addr;
      bit pad, err;
      r.op = OP_READ;
      addr = gather_sb.fetch_addr(r, pad, err);
      if (addr != NO_FETCH && !gather_sb.filled[addr]) begin
         fill            = random_fields();
         fill.op         = OP_WRITE;
         fill.in_frame   = FRAME_W'(addr / STORE_CH);
         fill.in_channel = CHAN_W'(addr % STORE_CH);
         send_beat(fill);
      end
      send_beat(r);
   endtask

   task automatic send_pair(logic [6:0] frame, logic [8:0] col);
      req_item_type r;
      r           = random_fields();
      r.out_frame = frame;
      r.out_col   = col;
      send_read(r);
   endtask

   task automatic send_write(logic [6:0] frame, logic [4:0] chan, logic [31:0] word);
      req_item_type r;
      r            = random_fields();
      r.op         = OP_WRITE;
      r.in_frame   = frame;
      r.in_channel = chan;
      r.in_word    = word;
      send_beat(r);
   endtask

   // Lower start, then wait until every owed beat has come and the block is quiet.
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (gather_sb.rsp_due.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   // One register write: setup cycle, then access cycle until pready.
   task automatic csr_write(csr_index_type idx, logic [31:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      gather_sb.set_reg(idx, value);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   // Write all four registers with junk in the bits above each field.
   task automatic configure(int ks, int st, int nc, int nf);
      drain();
      csr_write(REG_KERNEL_SIZE,   ($urandom << 5) | ks);
      csr_write(REG_STRIDE,        ($urandom << 5) | st);
      csr_write(REG_NUM_CHANNELS,  ($urandom << 6) | nc);
      csr_write(REG_NUM_IN_FRAMES, ($urandom << 8) | nf);
   endtask

   // Random mix: writes anywhere, reads mostly inside the configured sizes.
   task automatic run_random(int count);
      req_item_type r;
      int frames, cols;
      repeat (count) begin
         r = random_fields();
         gather_sb.out_limits(frames, cols);
         if ($urandom_range(0, 99) < 35) begin
            r.op = OP_WRITE;
            send_beat(r);
         end else begin
            if (frames > 0 && $urandom_range(0, 9) != 0)
               r.out_frame = FRAME_W'($urandom_range(0, frames - 1));
            if ($urandom_range(0, 9) != 0) r.out_col = COL_W'($urandom_range(0, cols - 1));
            send_read(r);
         end
      end
   endtask

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      psel     = 1'b0;
      penable  = 1'b0;
      pwrite   = 1'b0;
      paddr    = '0;
      pwdata   = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset sizes: word extremes, taps off both ends, column and frame limits.
      send_write(7'd0, 5'd0, 32'h0000_0000);
      send_write(7'd127, 5'd31, 32'hFFFF_FFFF);
      send_write(7'd64, 5'd16, 32'hA5A5_5A5A);
      send_pair(7'd0, 9'd0);
      send_pair(7'd0, 9'd1);
      send_pair(7'd0, 9'd2);
      send_pair(7'd127, 9'd2);
      send_pair(7'd127, 9'd1);
      send_pair(7'd127, 9'd94);
      send_pair(7'd127, 9'd95);
      send_pair(7'd64, 9'd49);
      send_pair(7'd5, 9'd96);
      send_pair(7'd0, 9'd511);
      run_random(150);

      configure(1, 1, 1, 1);
      run_random(100);

      // Widest window and stride: output frame limit and the top column.
      configure(16, 16, 32, 128);
      send_pair(7'd8, 9'd0);
      send_pair(7'd0, 9'd0);
      send_pair(7'd7, 9'd511);
      send_pair(7'd7, 9'd0);
      run_random(150);

      // Zero registers act as one; oversized ones saturate.
      configure(0, 0, 0, 0);
      run_random(80);
      configure(31, 31, 63, 255);
      run_random(120);

      repeat (3) begin
         configure($urandom_range(1, 16), $urandom_range(1, 4),
                   $urandom_range(1, 32), $urandom_range(16, 128));
         run_random(130);
      end

      drain();
      if (gather_sb.fail_count == 0 && gather_sb.rsp_due.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #2000000;
      $display("tb_top failed");
      $finish;
   end

endmodule
